FILE: rtl/core/sqe_pkg.sv
// Shared constants and types for the simplex element quality pipeline.
`default_nettype none

package sqe_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned COORD_WIDTH_DEF       = 32;
  localparam int unsigned QUALITY_FRAC_BITS_DEF = 16;

  // Chunk width of the partial-product multipliers and their latency
  localparam int unsigned MUL_CHUNK   = 32;
  localparam int unsigned MUL_LATENCY = 3;

  // Scale factors: 12 = (2*sqrt(3))^2, 432 = (12*sqrt(3))^2
  localparam int unsigned TRI_K = 12;
  localparam int unsigned TET_K = 432;

  // Register file
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned REG_ELEMENT_KIND = 0;

  typedef enum logic {
    KIND_TRI = 1'b0,
    KIND_TET = 1'b1
  } elem_kind_e;

  // Control travelling alongside the root-search payload
  typedef struct packed {
    logic valid;
    logic degen;
  } sqe_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sqe_delay.sv
// Enabled shift line of fixed depth, cleared by reset.
`default_nettype none

module sqe_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] stage_q [N];

  // shift one place per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) stage_q[i] <= '0;
    end else if (en_i) begin
      stage_q[0] <= d_i;
      for (int i = 1; i < N; i++) stage_q[i] <= stage_q[i-1];
    end
  end

  assign q_o = stage_q[N-1];

endmodule

`default_nettype wire

FILE: rtl/core/sqe_mul.sv
// Signed multiplier built from registered 32x32 partial products, three stages.
`default_nettype none

module sqe_mul #(
  parameter int unsigned WA = 33,
  parameter int unsigned WB = 33
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [WA-1:0]  a_i,
  input  wire logic signed [WB-1:0]  b_i,
  output logic signed [WA+WB-1:0]    p_o
);
  import sqe_pkg::*;

  localparam int unsigned NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int unsigned AW = NA * MUL_CHUNK;
  localparam int unsigned BW = NB * MUL_CHUNK;
  localparam int unsigned RW = BW + MUL_CHUNK;
  localparam int unsigned PW = WA + WB;

  logic [AW-1:0]          mag_a;
  logic [BW-1:0]          mag_b;
  logic [2*MUL_CHUNK-1:0] pp_q [NA][NB];
  logic                   neg1_q, neg2_q;
  logic [RW-1:0]          row_d [NA];
  logic [RW-1:0]          row_q [NA];
  logic [AW+BW-1:0]       acc;
  logic [PW-1:0]          prod;
  logic signed [PW-1:0]   p_q;

  // magnitudes; the most negative value maps to its correct unsigned magnitude
  always_comb begin
    mag_a = AW'($unsigned(a_i[WA-1] ? -a_i : a_i));
    mag_b = BW'($unsigned(b_i[WB-1] ? -b_i : b_i));
  end

  // stage 1: chunk products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= (2*MUL_CHUNK)'(mag_a[i*MUL_CHUNK +: MUL_CHUNK]) *
                        (2*MUL_CHUNK)'(mag_b[j*MUL_CHUNK +: MUL_CHUNK]);
        end
      end
      neg1_q <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  // stage 2: one row per chunk of a
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (MUL_CHUNK*j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q  <= row_d;
      neg2_q <= neg1_q;
    end
  end

  // stage 3: rows summed, sign applied
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      acc = acc + ((AW+BW)'(row_q[i]) << (MUL_CHUNK*i));
    end
    prod = acc[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= neg2_q ? -$signed(prod) : $signed(prod);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/core/sqe_root_cell.sv
// One cell of the root-search chain: decides one bit of the quality.
`default_nettype none

module sqe_root_cell #(
  parameter int unsigned NW  = 256,
  parameter int unsigned KW  = 17,
  parameter int unsigned BIT = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire sqe_pkg::sqe_ctl_t ctl_i,
  input  wire logic [NW-1:0]    r_i,
  input  wire logic [NW-1:0]    t_i,
  input  wire logic [NW-1:0]    d_i,
  input  wire logic [KW-1:0]    k_i,
  output sqe_pkg::sqe_ctl_t     ctl_o,
  output logic      [NW-1:0]    r_o,
  output logic      [NW-1:0]    t_o,
  output logic      [NW-1:0]    d_o,
  output logic      [KW-1:0]    k_o
);
  import sqe_pkg::*;

  // r = num - k^2*den, t = k*den; setting this bit costs 2^(b+1)*t + 4^b*den
  logic [NW-1:0] inc;
  logic [NW:0]   diff;
  logic          fit;
  sqe_ctl_t      ctl_q;
  logic [NW-1:0] r_q, t_q, d_q;
  logic [KW-1:0] k_q;

  always_comb begin
    inc  = (t_i << (BIT + 1)) + (d_i << (2 * BIT));
    diff = {1'b0, r_i} - {1'b0, inc};
    fit  = !diff[NW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= fit ? diff[NW-1:0] : r_i;
      t_q <= fit ? t_i + (d_i << BIT) : t_i;
      d_q <= d_i;
      k_q <= fit ? (k_i | (KW'(1) << BIT)) : k_i;
    end
  end

  assign ctl_o = ctl_q;
  assign r_o   = r_q;
  assign t_o   = t_q;
  assign d_o   = d_q;
  assign k_o   = k_q;

endmodule

`default_nettype wire

FILE: rtl/core/simplex_element_quality.sv
// Throughput: one element per cycle; the multiplier stages and the root-search chain
// (one cell per quality bit) are fully pipelined, so every stage can hold an item of its own.
// The pipe stalls as a whole only while a result waits in the output register.
// Reset (rst_ni low, asynchronous) empties the pipe and sets element_kind to triangle.
`default_nettype none

module simplex_element_quality #(
  parameter int unsigned COORD_WIDTH       = sqe_pkg::COORD_WIDTH_DEF,
  parameter int unsigned QUALITY_FRAC_BITS = sqe_pkg::QUALITY_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [sqe_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [sqe_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [sqe_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                     pready,
  // element input
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_a_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_a_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_a_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_b_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_b_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_b_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_c_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_c_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_c_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_d_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_d_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]       vertex_d_z_i,
  // result output
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [QUALITY_FRAC_BITS:0]               quality_o,
  output logic                                     degenerate_o
);
  import sqe_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned Q    = QUALITY_FRAC_BITS;
  localparam int unsigned DW   = CW + 1;             // edge vector component
  localparam int unsigned PW   = 2 * DW;             // component product
  localparam int unsigned NCW  = PW + 1;             // normal component
  localparam int unsigned SW   = PW + 5;             // edge length sum
  localparam int unsigned NNW  = 2 * NCW + 2;        // |n|^2
  localparam int unsigned VW   = NCW + DW + 2;       // signed volume term
  localparam int unsigned S2W  = 2 * (SW + 1);
  localparam int unsigned S3W  = S2W + SW + 1;
  localparam int unsigned NUMW = 2 * VW + 9 + 2 * Q;
  localparam int unsigned NW0  = S3W + 2 * Q + 3;
  localparam int unsigned NW   = ((NUMW > NW0) ? NUMW : NW0) + 1;
  localparam int unsigned KW   = Q + 1;

  // edge endpoints: ab, ac, cb, ad, bd, cd
  localparam int unsigned P_HI [6] = '{1, 2, 1, 3, 3, 3};
  localparam int unsigned P_LO [6] = '{0, 0, 2, 0, 1, 2};

  logic en;
  logic out_valid_q;
  logic [Q:0] quality_q;
  logic degen_q;

  // ---------------- configuration ----------------
  elem_kind_e kind_q;
  logic       reg_hit;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == (APB_ADDR_W-2)'(REG_ELEMENT_KIND));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_TRI;
    end else if (psel && penable && pwrite && reg_hit) begin
      kind_q <= elem_kind_e'(pwdata[0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_hit ? APB_DATA_W'(kind_q) : '0;

  // whole pipe advances unless a finished result is held
  assign en         = !(out_valid_q && !out_ready_i);
  assign in_ready_o = en;

  // ---------------- stage 0: edge vectors ----------------
  logic signed [CW-1:0] vtx   [4][3];
  logic signed [DW-1:0] dif_q [6][3];
  logic                 v0_q;
  logic                 kind0_q;

  assign vtx[0] = '{vertex_a_x_i, vertex_a_y_i, vertex_a_z_i};
  assign vtx[1] = '{vertex_b_x_i, vertex_b_y_i, vertex_b_z_i};
  assign vtx[2] = '{vertex_c_x_i, vertex_c_y_i, vertex_c_z_i};
  assign vtx[3] = '{vertex_d_x_i, vertex_d_y_i, vertex_d_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      kind0_q <= 1'b0;
    end else if (en) begin
      v0_q    <= in_valid_i;
      kind0_q <= kind_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < 6; e++) begin
        for (int c = 0; c < 3; c++) begin
          dif_q[e][c] <= DW'(vtx[P_HI[e]][c]) - DW'(vtx[P_LO[e]][c]);
        end
      end
    end
  end

  // ---------------- multiply 1: squares and cross terms ----------------
  logic signed [PW-1:0] sq [6][3];
  logic signed [PW-1:0] cp [3][2];
  logic [1:0]           vk3;
  logic [3*DW-1:0]      ad3;

  for (genvar e = 0; e < 6; e++) begin : g_sq
    for (genvar c = 0; c < 3; c++) begin : g_c
      sqe_mul #(.WA(DW), .WB(DW)) u_sq (
        .clk_i, .en_i(en), .a_i(dif_q[e][c]), .b_i(dif_q[e][c]), .p_o(sq[e][c])
      );
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    sqe_mul #(.WA(DW), .WB(DW)) u_cp0 (
      .clk_i, .en_i(en), .a_i(dif_q[0][(i+1)%3]), .b_i(dif_q[1][(i+2)%3]), .p_o(cp[i][0])
    );
    sqe_mul #(.WA(DW), .WB(DW)) u_cp1 (
      .clk_i, .en_i(en), .a_i(dif_q[0][(i+2)%3]), .b_i(dif_q[1][(i+1)%3]), .p_o(cp[i][1])
    );
  end

  sqe_delay #(.W(2), .N(MUL_LATENCY)) u_dl_vk3 (
    .clk_i, .rst_ni, .en_i(en), .d_i({v0_q, kind0_q}), .q_o(vk3)
  );
  sqe_delay #(.W(3*DW), .N(MUL_LATENCY)) u_dl_ad3 (
    .clk_i, .rst_ni, .en_i(en), .d_i({dif_q[3][2], dif_q[3][1], dif_q[3][0]}), .q_o(ad3)
  );

  // ---------------- stage 4: normal and edge sum ----------------
  logic signed [NCW-1:0] n_q   [3];
  logic signed [DW-1:0]  ad4_q [3];
  logic [SW-1:0]         s4_q;
  logic [SW-1:0]         s_d;
  logic                  v4_q, kind4_q;

  always_comb begin
    s_d = '0;
    for (int e = 0; e < 6; e++) begin
      if (e < 3 || vk3[0]) begin
        for (int c = 0; c < 3; c++) s_d = s_d + SW'($unsigned(sq[e][c]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q    <= 1'b0;
      kind4_q <= 1'b0;
    end else if (en) begin
      v4_q    <= vk3[1];
      kind4_q <= vk3[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i]   <= NCW'(cp[i][0]) - NCW'(cp[i][1]);
        ad4_q[i] <= $signed(ad3[i*DW +: DW]);
      end
      s4_q <= s_d;
    end
  end

  // ---------------- multiply 2: |n|^2 terms, volume terms, S^2 ----------------
  logic signed [2*NCW-1:0]    nnp [3];
  logic signed [NCW+DW-1:0]   vtp [3];
  logic signed [S2W-1:0]      s2p;
  logic [1:0]                 vk7;
  logic [SW-1:0]              s7;

  for (genvar i = 0; i < 3; i++) begin : g_m2
    sqe_mul #(.WA(NCW), .WB(NCW)) u_nn (
      .clk_i, .en_i(en), .a_i(n_q[i]), .b_i(n_q[i]), .p_o(nnp[i])
    );
    sqe_mul #(.WA(NCW), .WB(DW)) u_vt (
      .clk_i, .en_i(en), .a_i(n_q[i]), .b_i(ad4_q[i]), .p_o(vtp[i])
    );
  end

  sqe_mul #(.WA(SW+1), .WB(SW+1)) u_s2 (
    .clk_i, .en_i(en), .a_i($signed({1'b0, s4_q})), .b_i($signed({1'b0, s4_q})), .p_o(s2p)
  );

  sqe_delay #(.W(2), .N(MUL_LATENCY)) u_dl_vk7 (
    .clk_i, .rst_ni, .en_i(en), .d_i({v4_q, kind4_q}), .q_o(vk7)
  );
  sqe_delay #(.W(SW), .N(MUL_LATENCY)) u_dl_s7 (
    .clk_i, .rst_ni, .en_i(en), .d_i(s4_q), .q_o(s7)
  );

  // ---------------- stage 8: |n|^2, volume, S^2 ----------------
  logic [NNW-1:0]        nn_q;
  logic signed [VW-1:0]  vol_q;
  logic signed [S2W-1:0] s2_q;
  logic [SW-1:0]         s8_q;
  logic [2:0]            ctl8_q;   // valid, kind, degenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl8_q <= '0;
    end else if (en) begin
      ctl8_q <= {vk7[1], vk7[0], (s7 == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nn_q  <= NNW'($unsigned(nnp[0])) + NNW'($unsigned(nnp[1])) + NNW'($unsigned(nnp[2]));
      vol_q <= VW'(vtp[0]) + VW'(vtp[1]) + VW'(vtp[2]);
      s2_q  <= s2p;
      s8_q  <= s7;
    end
  end

  // ---------------- multiply 3: volume squared, S^3 ----------------
  logic signed [2*VW-1:0] vvp;
  logic signed [S3W-1:0]  s3p;
  logic [2:0]             ctl11;
  logic [NNW-1:0]         nn11;
  logic [S2W-1:0]         s2_11;

  sqe_mul #(.WA(VW), .WB(VW)) u_vv (
    .clk_i, .en_i(en), .a_i(vol_q), .b_i(vol_q), .p_o(vvp)
  );
  sqe_mul #(.WA(S2W), .WB(SW+1)) u_s3 (
    .clk_i, .en_i(en), .a_i(s2_q), .b_i($signed({1'b0, s8_q})), .p_o(s3p)
  );

  sqe_delay #(.W(3), .N(MUL_LATENCY)) u_dl_ctl11 (
    .clk_i, .rst_ni, .en_i(en), .d_i(ctl8_q), .q_o(ctl11)
  );
  sqe_delay #(.W(NNW), .N(MUL_LATENCY)) u_dl_nn11 (
    .clk_i, .rst_ni, .en_i(en), .d_i(nn_q), .q_o(nn11)
  );
  sqe_delay #(.W(S2W), .N(MUL_LATENCY)) u_dl_s2_11 (
    .clk_i, .rst_ni, .en_i(en), .d_i($unsigned(s2_q)), .q_o(s2_11)
  );

  // ---------------- stage 12: ratio operands ----------------
  sqe_ctl_t      ctl12_q;
  logic [NW-1:0] num_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl12_q <= '0;
    end else if (en) begin
      ctl12_q <= '{valid: ctl11[2], degen: ctl11[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (elem_kind_e'(ctl11[1]) == KIND_TET) begin
        num_q <= (NW'($unsigned(vvp)) * NW'(TET_K)) << (2 * Q);
        den_q <= NW'($unsigned(s3p));
      end else begin
        num_q <= (NW'(nn11) * NW'(TRI_K)) << (2 * Q);
        den_q <= NW'(s2_11);
      end
    end
  end

  // ---------------- root-search chain, most significant bit first ----------------
  sqe_ctl_t      ctl_c [KW+1];
  logic [NW-1:0] r_c   [KW+1];
  logic [NW-1:0] t_c   [KW+1];
  logic [NW-1:0] d_c   [KW+1];
  logic [KW-1:0] k_c   [KW+1];

  assign ctl_c[0] = ctl12_q;
  assign r_c[0]   = num_q;
  assign t_c[0]   = '0;
  assign d_c[0]   = den_q;
  assign k_c[0]   = '0;

  for (genvar i = 0; i < KW; i++) begin : g_cell
    sqe_root_cell #(.NW(NW), .KW(KW), .BIT(KW - 1 - i)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .ctl_i(ctl_c[i]), .r_i(r_c[i]), .t_i(t_c[i]), .d_i(d_c[i]), .k_i(k_c[i]),
      .ctl_o(ctl_c[i+1]), .r_o(r_c[i+1]), .t_o(t_c[i+1]), .d_o(d_c[i+1]), .k_o(k_c[i+1])
    );
  end

  // ---------------- output register ----------------
  localparam logic [KW-1:0] ONE_Q = KW'(1) << Q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_c[KW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen_q <= ctl_c[KW].degen;
      if (ctl_c[KW].degen) begin
        quality_q <= '0;
      end else if (k_c[KW] > ONE_Q) begin
        quality_q <= ONE_Q;
      end else begin
        quality_q <= k_c[KW];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign quality_o    = quality_q;
  assign degenerate_o = degen_q;

endmodule

`default_nettype wire

FILE: rtl/core/sqe_checker.sv
// Port-level checks for the simplex element quality block, bound to the top level.
`default_nettype none

module sqe_checker #(
  parameter int unsigned QUALITY_FRAC_BITS = sqe_pkg::QUALITY_FRAC_BITS_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [QUALITY_FRAC_BITS:0] quality_o,
  input wire logic                       degenerate_o
);

  localparam logic [QUALITY_FRAC_BITS:0] ONE_Q = (QUALITY_FRAC_BITS+1)'(1) << QUALITY_FRAC_BITS;

  // held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quality_o) && $stable(degenerate_o))
    else $error("result changed while stalled");

  // degenerate element reports zero quality
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> quality_o == '0)
    else $error("degenerate element with nonzero quality");

  // quality never exceeds 1.0
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quality_o <= ONE_Q)
    else $error("quality above 1.0");

  // input is only held back by a waiting result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input stalled without a held result");

endmodule

bind simplex_element_quality sqe_checker #(
  .QUALITY_FRAC_BITS(QUALITY_FRAC_BITS)
) u_sqe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .quality_o   (quality_o),
  .degenerate_o(degenerate_o)
);

`default_nettype wire
